FILE: design/rpis_pkg.sv
// ---------------------------------------------------------------------------
// rpis_pkg: shared types and constants for read pair insert statistics
// Field widths, register indexes, vote codes and the queue entry layout.
// ---------------------------------------------------------------------------
package rpis_pkg;

   // field widths
   localparam int QUAL_W       = 8;
   localparam int LIMIT_W      = 31;
   localparam int ID_W         = 32;
   localparam int POS_W        = 32;
   localparam int LEN_W        = 16;
   localparam int INSERT_W     = 31;
   localparam int MAX_EST_W    = 31;
   localparam int MIN_EST_W    = 18;
   localparam int PAIRS_W      = 32;
   localparam int INSERT_SUM_W = 64;
   localparam int LENGTH_SUM_W = 48;
   localparam int VOTE_W       = 33;

   // divider numerator covers twice the insert sum
   localparam int DIV_NUM_W    = INSERT_SUM_W + 1;

   // front to back queue, power of two depth
   localparam int QUEUE_DEPTH  = 4;

   // configuration port
   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;
   localparam logic CSR_IDX_QUALITY = 1'b0;
   localparam logic CSR_IDX_LIMIT   = 1'b1;

   localparam logic [QUAL_W-1:0]  QUALITY_RESET   = 8'd0;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET     = 31'd100000;
   localparam logic [LEN_W-1:0]   MIN_READ_LENGTH = 16'd30;

   // signed vote limits
   localparam logic [VOTE_W-1:0]  VOTE_MAX = {1'b0, {(VOTE_W-1){1'b1}}};
   localparam logic [VOTE_W-1:0]  VOTE_MIN = {1'b1, {(VOTE_W-1){1'b0}}};

   // orientation vote of one pair
   typedef enum logic [1:0] {
      VOTE_NONE = 2'd0,
      VOTE_UP   = 2'd1,
      VOTE_DOWN = 2'd2
   } vote_type;

   // one classified record
   typedef struct packed {
      logic                usable;
      logic [INSERT_W-1:0] insert;
      logic [LEN_W-1:0]    length;
      vote_type            vote;
      logic                last;
   } rpis_entry_type;

endpackage

FILE: design/rpis_if.sv
// ---------------------------------------------------------------------------
// rpis_if: record and result channels
// Valid/ready channels carrying one aligned-read record or one result.
// ---------------------------------------------------------------------------
interface rpis_req_if import rpis_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic                    is_mapped;
   logic [QUAL_W-1:0]       map_quality;
   logic signed [ID_W-1:0]  reference_id;
   logic signed [ID_W-1:0]  mate_reference_id;
   logic signed [POS_W-1:0] read_position;
   logic signed [POS_W-1:0] mate_position;
   logic [LEN_W-1:0]        read_length;
   logic                    read_reverse;
   logic                    mate_reverse;
   logic                    last_record;

   modport source (
      output valid, is_mapped, map_quality, reference_id, mate_reference_id,
             read_position, mate_position, read_length, read_reverse,
             mate_reverse, last_record,
      input  ready
   );
   modport sink (
      input  valid, is_mapped, map_quality, reference_id, mate_reference_id,
             read_position, mate_position, read_length, read_reverse,
             mate_reverse, last_record,
      output ready
   );
endinterface

interface rpis_rsp_if import rpis_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [MAX_EST_W-1:0] max_insert_estimate;
   logic [MIN_EST_W-1:0] min_insert_estimate;
   logic                 is_outtie;
   logic [PAIRS_W-1:0]   pairs_used;

   modport source (
      output valid, max_insert_estimate, min_insert_estimate, is_outtie,
             pairs_used,
      input  ready
   );
   modport sink (
      input  valid, max_insert_estimate, min_insert_estimate, is_outtie,
             pairs_used,
      output ready
   );
endinterface

FILE: design/rpis_front.sv
// ---------------------------------------------------------------------------
// rpis_front: record intake and pair filter
// Accepts a record beat, applies the pair filter and pushes the classified
// entry into the queue.
// ---------------------------------------------------------------------------
module rpis_front import rpis_pkg::*; (
   rpis_req_if.sink             req_chan,
   input  logic [QUAL_W-1:0]    quality_threshold,
   input  logic [LIMIT_W-1:0]   max_insert_limit,
   input  logic                 q_full,
   output logic                 q_push,
   output rpis_entry_type       q_entry
);

   logic signed [POS_W:0] pos_diff;
   logic [POS_W:0]        insert_full;
   logic                  pos_ok;
   logic                  insert_ok;
   logic                  quality_ok;
   logic                  ref_ok;
   logic                  length_ok;

   // take a beat whenever the queue has room
   assign req_chan.ready = !q_full;
   assign q_push         = req_chan.valid && !q_full;

   // filter terms
   always_comb begin
      pos_diff    = $signed({req_chan.mate_position[POS_W-1], req_chan.mate_position})
                  - $signed({req_chan.read_position[POS_W-1], req_chan.read_position});
      pos_ok      = !pos_diff[POS_W];
      insert_full = {1'b0, pos_diff[POS_W-1:0]} + (POS_W+1)'(1);
      insert_ok   = insert_full < {{(POS_W+1-LIMIT_W){1'b0}}, max_insert_limit};
      quality_ok  = req_chan.map_quality > quality_threshold;
      ref_ok      = req_chan.reference_id == req_chan.mate_reference_id;
      length_ok   = req_chan.read_length > MIN_READ_LENGTH;
   end

   // classified entry
   always_comb begin
      q_entry.usable = req_chan.is_mapped && quality_ok && ref_ok && pos_ok
                     && insert_ok && length_ok;
      q_entry.insert = insert_full[INSERT_W-1:0];
      q_entry.length = req_chan.read_length;
      q_entry.last   = req_chan.last_record;
      priority if (req_chan.read_reverse && !req_chan.mate_reverse) begin
         q_entry.vote = VOTE_UP;
      end else if (!req_chan.read_reverse && req_chan.mate_reverse) begin
         q_entry.vote = VOTE_DOWN;
      end else begin
         q_entry.vote = VOTE_NONE;
      end
   end

endmodule

FILE: design/rpis_queue.sv
// ---------------------------------------------------------------------------
// rpis_queue: classified entry queue
// Small register queue that decouples the filter from the accumulator.
// ---------------------------------------------------------------------------
module rpis_queue import rpis_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           q_push,
   input  rpis_entry_type q_entry,
   input  logic           q_pop,
   output rpis_entry_type q_head,
   output logic           q_full,
   output logic           q_empty
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam logic [PTR_W:0] DEPTH_CNT = (PTR_W+1)'(QUEUE_DEPTH);

   rpis_entry_type   slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [PTR_W:0]   fill_ff;
   logic [PTR_W:0]   fill_in;

   assign q_full  = fill_ff == DEPTH_CNT;
   assign q_empty = fill_ff == '0;
   assign q_head  = slot_ff[rd_ptr_ff];

   // pointer and fill update, pointers wrap at the depth
   always_comb begin
      wr_ptr_in = q_push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = q_pop  ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      fill_in   = fill_ff;
      if (q_push && !q_pop) begin
         fill_in = fill_ff + (PTR_W+1)'(1);
      end else if (!q_push && q_pop) begin
         fill_in = fill_ff - (PTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (q_push) begin
         slot_ff[wr_ptr_ff] <= q_entry;
      end
   end

endmodule

FILE: design/rpis_div.sv
// ---------------------------------------------------------------------------
// rpis_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle over the full numerator.
// ---------------------------------------------------------------------------
module rpis_div import rpis_pkg::*; #(
   parameter int DEN_W = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [DIV_NUM_W-1:0] numerator,
   input  logic [DEN_W-1:0]     denominator,
   output logic                 done,
   output logic [DIV_NUM_W-1:0] quotient
);

   localparam int STEP_W = $clog2(DIV_NUM_W + 1);
   localparam logic [STEP_W-1:0] STEP_LAST  = STEP_W'(1);
   localparam logic [STEP_W-1:0] STEP_COUNT = STEP_W'(DIV_NUM_W);

   logic [DEN_W-1:0]     rem_ff;
   logic [DEN_W-1:0]     rem_in;
   logic [DIV_NUM_W-1:0] quo_ff;
   logic [DIV_NUM_W-1:0] quo_in;
   logic [DEN_W-1:0]     den_ff;
   logic [DEN_W-1:0]     den_in;
   logic [STEP_W-1:0]    step_ff;
   logic [STEP_W-1:0]    step_in;
   logic                 busy_ff;
   logic                 busy_in;
   logic                 done_ff;
   logic                 done_in;
   logic [DEN_W:0]       shifted;
   logic [DEN_W+1:0]     trial;
   logic                 fits;

   assign done     = done_ff;
   assign quotient = quo_ff;

   // one trial subtraction per cycle
   always_comb begin
      shifted = {rem_ff, quo_ff[DIV_NUM_W-1]};
      trial   = {1'b0, shifted} - {2'b0, den_ff};
      fits    = !trial[DEN_W+1];
   end

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = numerator;
         den_in  = denominator;
         step_in = STEP_COUNT;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = fits ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];
         quo_in  = {quo_ff[DIV_NUM_W-2:0], fits};
         step_in = step_ff - STEP_W'(1);
         if (step_ff == STEP_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

endmodule

FILE: design/rpis_back.sv
// ---------------------------------------------------------------------------
// rpis_back: pair accumulator and result builder
// Pops classified entries, keeps saturating sums, count and vote; on the last
// record runs both divisions if a pair was used and loads the result register.
// ---------------------------------------------------------------------------
module rpis_back import rpis_pkg::*; #(
   parameter int COUNT_BITS = 32
) (
   input  logic           clock,
   input  logic           reset,
   input  rpis_entry_type q_head,
   input  logic           q_empty,
   output logic           q_pop,
   rpis_rsp_if.source     rsp_chan
);

   localparam logic [2:0] ST_ACC     = 3'd0;
   localparam logic [2:0] ST_START   = 3'd1;
   localparam logic [2:0] ST_DIV_MAX = 3'd2;
   localparam logic [2:0] ST_DIV_MIN = 3'd3;
   localparam logic [2:0] ST_OUT     = 3'd4;

   localparam int LEN3_W = LENGTH_SUM_W + 2;

   logic [2:0]              state_ff;
   logic [2:0]              state_in;
   logic [INSERT_SUM_W-1:0] insert_sum_ff;
   logic [INSERT_SUM_W-1:0] insert_sum_in;
   logic [LENGTH_SUM_W-1:0] length_sum_ff;
   logic [LENGTH_SUM_W-1:0] length_sum_in;
   logic [COUNT_BITS-1:0]   count_ff;
   logic [COUNT_BITS-1:0]   count_in;
   logic [VOTE_W-1:0]       vote_ff;
   logic [VOTE_W-1:0]       vote_in;
   logic [MAX_EST_W-1:0]    max_est_ff;
   logic [MAX_EST_W-1:0]    max_est_in;
   logic [MIN_EST_W-1:0]    min_est_ff;
   logic [MIN_EST_W-1:0]    min_est_in;
   logic                    out_valid_ff;
   logic                    out_valid_in;
   logic [MAX_EST_W-1:0]    out_max_ff;
   logic [MAX_EST_W-1:0]    out_max_in;
   logic [MIN_EST_W-1:0]    out_min_ff;
   logic [MIN_EST_W-1:0]    out_min_in;
   logic                    out_outtie_ff;
   logic                    out_outtie_in;
   logic [PAIRS_W-1:0]      out_pairs_ff;
   logic [PAIRS_W-1:0]      out_pairs_in;

   logic                    take;
   logic [INSERT_SUM_W:0]   insert_add;
   logic [LENGTH_SUM_W:0]   length_add;
   logic [LEN3_W-1:0]       length3;
   logic [63:0]             count_wide;
   logic                    div_start;
   logic [DIV_NUM_W-1:0]    div_num;
   logic                    div_done;
   logic [DIV_NUM_W-1:0]    div_quo;
   logic                    load_out;

   // shared divider for both estimates
   rpis_div #(
      .DEN_W (COUNT_BITS)
   ) u_div (
      .clock       (clock),
      .reset       (reset),
      .start       (div_start),
      .numerator   (div_num),
      .denominator (count_ff),
      .done        (div_done),
      .quotient    (div_quo)
   );

   // result channel
   assign rsp_chan.valid               = out_valid_ff;
   assign rsp_chan.max_insert_estimate = out_max_ff;
   assign rsp_chan.min_insert_estimate = out_min_ff;
   assign rsp_chan.is_outtie           = out_outtie_ff;
   assign rsp_chan.pairs_used          = out_pairs_ff;

   // accumulator adders and numerators
   always_comb begin
      take       = q_head.usable && !(&count_ff);
      insert_add = {1'b0, insert_sum_ff}
                 + {{(INSERT_SUM_W+1-INSERT_W){1'b0}}, q_head.insert};
      length_add = {1'b0, length_sum_ff}
                 + {{(LENGTH_SUM_W+1-LEN_W){1'b0}}, q_head.length};
      length3    = {1'b0, length_sum_ff, 1'b0} + {2'b0, length_sum_ff};
      count_wide = 64'(count_ff);
      load_out   = !out_valid_ff || rsp_chan.ready;
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      insert_sum_in = insert_sum_ff;
      length_sum_in = length_sum_ff;
      count_in      = count_ff;
      vote_in       = vote_ff;
      max_est_in    = max_est_ff;
      min_est_in    = min_est_ff;
      out_valid_in  = out_valid_ff && !rsp_chan.ready;
      out_max_in    = out_max_ff;
      out_min_in    = out_min_ff;
      out_outtie_in = out_outtie_ff;
      out_pairs_in  = out_pairs_ff;
      q_pop         = 1'b0;
      div_start     = 1'b0;
      div_num       = {insert_sum_ff, 1'b0};

      unique case (state_ff)
         ST_ACC: begin
            if (!q_empty) begin
               q_pop = 1'b1;
               if (take) begin
                  insert_sum_in = insert_add[INSERT_SUM_W] ? '1
                                : insert_add[INSERT_SUM_W-1:0];
                  length_sum_in = length_add[LENGTH_SUM_W] ? '1
                                : length_add[LENGTH_SUM_W-1:0];
                  count_in      = count_ff + COUNT_BITS'(1);
                  unique case (q_head.vote)
                     VOTE_UP: begin
                        if (vote_ff != VOTE_MAX) begin
                           vote_in = vote_ff + VOTE_W'(1);
                        end
                     end
                     VOTE_DOWN: begin
                        if (vote_ff != VOTE_MIN) begin
                           vote_in = vote_ff - VOTE_W'(1);
                        end
                     end
                     default: begin
                        vote_in = vote_ff;
                     end
                  endcase
               end
               if (q_head.last) begin
                  state_in = ST_START;
               end
            end
         end
         ST_START: begin
            if (count_ff == '0) begin
               max_est_in = '0;
               min_est_in = '0;
               state_in   = ST_OUT;
            end else begin
               div_start = 1'b1;
               div_num   = {insert_sum_ff, 1'b0};
               state_in  = ST_DIV_MAX;
            end
         end
         ST_DIV_MAX: begin
            if (div_done) begin
               max_est_in = (|div_quo[DIV_NUM_W-1:MAX_EST_W]) ? '1
                          : div_quo[MAX_EST_W-1:0];
               div_start  = 1'b1;
               div_num    = {{(DIV_NUM_W-LEN3_W){1'b0}}, length3};
               state_in   = ST_DIV_MIN;
            end
         end
         ST_DIV_MIN: begin
            if (div_done) begin
               min_est_in = (|div_quo[DIV_NUM_W-1:MIN_EST_W]) ? '1
                          : div_quo[MIN_EST_W-1:0];
               state_in   = ST_OUT;
            end
         end
         ST_OUT: begin
            if (load_out) begin
               out_valid_in  = 1'b1;
               out_max_in    = max_est_ff;
               out_min_in    = min_est_ff;
               out_outtie_in = !vote_ff[VOTE_W-1] && (vote_ff != '0);
               out_pairs_in  = (count_wide > 64'h0000_0000_FFFF_FFFF) ? '1
                             : count_wide[PAIRS_W-1:0];
               insert_sum_in = '0;
               length_sum_in = '0;
               count_in      = '0;
               vote_in       = '0;
               state_in      = ST_ACC;
            end
         end
         default: begin
            state_in = ST_ACC;
         end
      endcase
   end

   // control and accumulator state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_ACC;
         out_valid_ff  <= 1'b0;
         insert_sum_ff <= '0;
         length_sum_ff <= '0;
         count_ff      <= '0;
         vote_ff       <= '0;
      end else begin
         state_ff      <= state_in;
         out_valid_ff  <= out_valid_in;
         insert_sum_ff <= insert_sum_in;
         length_sum_ff <= length_sum_in;
         count_ff      <= count_in;
         vote_ff       <= vote_in;
      end
   end

   // estimates and result payload
   always_ff @(posedge clock) begin
      max_est_ff    <= max_est_in;
      min_est_ff    <= min_est_in;
      out_max_ff    <= out_max_in;
      out_min_ff    <= out_min_in;
      out_outtie_ff <= out_outtie_in;
      out_pairs_ff  <= out_pairs_in;
   end

endmodule

FILE: design/read_pair_insert_statistics.sv
// ---------------------------------------------------------------------------
// read_pair_insert_statistics: insert size statistics over aligned read pairs
// Records are accepted at one per cycle while the queue has room; up to four
// wait while the back is busy. The last record of a batch yields one result
// from two 65-step divisions in the shared divider.
// A batch with no usable pair skips the divisions.
// Reset clears the sums, count, vote and queue and restores register defaults.
// ---------------------------------------------------------------------------
module read_pair_insert_statistics import rpis_pkg::*; #(
   parameter int COUNT_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   rpis_req_if.sink              req_chan,
   rpis_rsp_if.source            rsp_chan,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   logic [QUAL_W-1:0]  quality_threshold_ff;
   logic [QUAL_W-1:0]  quality_threshold_in;
   logic [LIMIT_W-1:0] max_insert_limit_ff;
   logic [LIMIT_W-1:0] max_insert_limit_in;
   logic               csr_write;

   logic               q_push;
   logic               q_pop;
   logic               q_full;
   logic               q_empty;
   rpis_entry_type     q_entry;
   rpis_entry_type     q_head;

   // configuration registers
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_comb begin
      quality_threshold_in = quality_threshold_ff;
      max_insert_limit_in  = max_insert_limit_ff;
      if (csr_write) begin
         unique case (paddr[2])
            CSR_IDX_QUALITY: quality_threshold_in = pwdata[QUAL_W-1:0];
            CSR_IDX_LIMIT:   max_insert_limit_in  = pwdata[LIMIT_W-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         CSR_IDX_QUALITY: prdata = {{(CSR_DATA_W-QUAL_W){1'b0}}, quality_threshold_ff};
         CSR_IDX_LIMIT:   prdata = {{(CSR_DATA_W-LIMIT_W){1'b0}}, max_insert_limit_ff};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quality_threshold_ff <= QUALITY_RESET;
         max_insert_limit_ff  <= LIMIT_RESET;
      end else begin
         quality_threshold_ff <= quality_threshold_in;
         max_insert_limit_ff  <= max_insert_limit_in;
      end
   end

   // filter front
   rpis_front u_front (
      .req_chan          (req_chan),
      .quality_threshold (quality_threshold_ff),
      .max_insert_limit  (max_insert_limit_ff),
      .q_full            (q_full),
      .q_push            (q_push),
      .q_entry           (q_entry)
   );

   // decoupling queue
   rpis_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .q_push  (q_push),
      .q_entry (q_entry),
      .q_pop   (q_pop),
      .q_head  (q_head),
      .q_full  (q_full),
      .q_empty (q_empty)
   );

   // accumulator and result back end
   rpis_back #(
      .COUNT_BITS (COUNT_BITS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_head   (q_head),
      .q_empty  (q_empty),
      .q_pop    (q_pop),
      .rsp_chan (rsp_chan)
   );

   // checks
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("queue push while full");

   a_pop_data: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("queue pop while empty");

   a_last_stalls: assert property (@(posedge clock) disable iff (reset)
      q_pop && q_head.last |=> !q_pop)
      else $error("queue pop right after last record");

endmodule
